/* sv/mss_pkg.sv */
`default_nettype none
package mss_pkg;

  localparam int MaxStuffingDefault = 16;

  // event kinds
  localparam logic [2:0] KIND_PACK   = 3'd0;
  localparam logic [2:0] KIND_SYSHDR = 3'd1;
  localparam logic [2:0] KIND_ENTRY  = 3'd2;
  localparam logic [2:0] KIND_PACKET = 3'd3;
  localparam logic [2:0] KIND_DATA   = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;
  localparam logic [2:0] KIND_END    = 3'd6;

  // error codes
  localparam logic [3:0] ERR_START_CODE = 4'd0;
  localparam logic [3:0] ERR_MARKER     = 4'd1;
  localparam logic [3:0] ERR_SHORT_HDR  = 4'd2;
  localparam logic [3:0] ERR_RESERVED   = 4'd3;
  localparam logic [3:0] ERR_TS_FLAGS   = 4'd4;
  localparam logic [3:0] ERR_DTS_PREFIX = 4'd5;
  localparam logic [3:0] ERR_NO_TS_BYTE = 4'd6;
  localparam logic [3:0] ERR_TRUNCATED  = 4'd7;
  localparam logic [3:0] ERR_UNDERFLOW  = 4'd8;

  localparam logic [31:0] PACK_CODE   = 32'h0000_01BA;
  localparam logic [31:0] SYS_CODE    = 32'h0000_01BB;
  localparam logic [31:0] STREAM_LO   = 32'h0000_01BD;
  localparam logic [31:0] STREAM_HI   = 32'h0000_01EF;
  localparam logic [7:0]  STUFF_BYTE  = 8'hFF;
  localparam logic [7:0]  NO_TS_BYTE  = 8'h0F;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  stream_num;
    logic [32:0] time_stamp;
    logic [32:0] decode_time;
    logic [21:0] rate;
    logic [15:0] length;
    logic [1:0]  time_flags;
    logic        std_scale;
    logic [12:0] std_size;
    logic [14:0] system_bounds;
    logic [7:0]  data_byte;
    logic [3:0]  error_code;
  } event_t;

  // 33-bit time from five bytes: hhh m / 15 m / 15 m
  function automatic logic [32:0] time_of(input logic [39:0] v);
    time_of = {v[35:33], v[31:17], v[15:1]};
  endfunction

endpackage
`default_nettype wire

/* sv/mss_ifs.sv */
`default_nettype none
interface mss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;
  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface mss_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  stream_num;
  logic [32:0] time_stamp;
  logic [32:0] decode_time;
  logic [21:0] rate;
  logic [15:0] length;
  logic [1:0]  time_flags;
  logic        std_scale;
  logic [12:0] std_size;
  logic [14:0] system_bounds;
  logic [7:0]  data_byte;
  logic [3:0]  error_code;
  modport source (output valid, output kind, output stream_num, output time_stamp,
                  output decode_time, output rate, output length, output time_flags,
                  output std_scale, output std_size, output system_bounds,
                  output data_byte, output error_code, input ready);
  modport sink   (input valid, input kind, input stream_num, input time_stamp,
                  input decode_time, input rate, input length, input time_flags,
                  input std_scale, input std_size, input system_bounds,
                  input data_byte, input error_code, output ready);
endinterface
`default_nettype wire

/* sv/mss_parse_core.sv */
`default_nettype none
module mss_parse_core #(
  parameter int MAX_STUFFING = mss_pkg::MaxStuffingDefault
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic [7:0]     in_byte,
  input  wire logic           end_of_stream,
  output logic                ev_valid,
  output mss_pkg::event_t     ev
);
  import mss_pkg::*;

  localparam int SW = $clog2(MAX_STUFFING + 1);
  localparam logic [SW-1:0] STUFF_MAX = SW'(MAX_STUFFING);

  localparam logic [3:0] PH_CODE_START    = 4'd0;
  localparam logic [3:0] PH_CODE_PACK     = 4'd1;
  localparam logic [3:0] PH_CODE_MID      = 4'd2;
  localparam logic [3:0] PH_PACK          = 4'd3;
  localparam logic [3:0] PH_SYS           = 4'd4;
  localparam logic [3:0] PH_ENTRY_OR_CODE = 4'd5;
  localparam logic [3:0] PH_ENTRY         = 4'd6;
  localparam logic [3:0] PH_PLEN          = 4'd7;
  localparam logic [3:0] PH_STUFF         = 4'd8;
  localparam logic [3:0] PH_STD           = 4'd9;
  localparam logic [3:0] PH_TSLEAD        = 4'd10;
  localparam logic [3:0] PH_PTS           = 4'd11;
  localparam logic [3:0] PH_DTS           = 4'd12;
  localparam logic [3:0] PH_DATA          = 4'd13;
  localparam logic [3:0] PH_DONE          = 4'd14;

  logic [3:0]    ph_r, ph_nxt;
  logic [2:0]    fbc_r, fbc_nxt;
  logic [63:0]   hs0_r, hs0_nxt;
  logic [31:0]   hs1_r, hs1_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [SW-1:0] stuff_r, stuff_nxt;
  logic [7:0]    sid_r, sid_nxt;
  logic [32:0]   pts_r, pts_nxt;
  logic          err_r, err_nxt;

  logic [63:0] sh;
  logic [31:0] code;
  logic [1:0]  f;
  logic        do_lead, do_done, do_fail, clean;
  logic [3:0]  fail_code;
  logic [32:0] done_pts, done_dts;
  logic [15:0] done_rem, rem_dec;

  assign sh   = {hs0_r[55:0], in_byte};
  assign code = sh[31:0];
  assign f    = in_byte[5:4];

  always_comb begin
    ph_nxt = ph_r; fbc_nxt = fbc_r; hs0_nxt = hs0_r; hs1_nxt = hs1_r;
    rem_nxt = rem_r; stuff_nxt = stuff_r; sid_nxt = sid_r; pts_nxt = pts_r;
    err_nxt = err_r;
    ev_valid = 1'b0; ev = '0;
    do_lead = 1'b0; do_done = 1'b0; do_fail = 1'b0; fail_code = ERR_START_CODE;
    done_pts = pts_r; done_dts = '0; done_rem = rem_r;
    rem_dec = (rem_r != 16'd0) ? rem_r - 16'd1 : 16'd0;
    clean = (ph_r == PH_ENTRY_OR_CODE) ||
            ((ph_r == PH_CODE_START || ph_r == PH_CODE_PACK || ph_r == PH_CODE_MID) &&
             fbc_r == 3'd0);
    if (en && !err_r && ph_r != PH_DONE) begin
      if (end_of_stream) begin
        if (clean) begin
          ph_nxt = PH_DONE;
          ev_valid = 1'b1;
          ev.kind = KIND_END;
        end else begin
          do_fail = 1'b1; fail_code = ERR_TRUNCATED;
        end
      end else begin
        case (ph_r)
          PH_CODE_START, PH_CODE_PACK, PH_CODE_MID: begin
            hs0_nxt = sh;
            if (fbc_r == 3'd3) begin
              fbc_nxt = 3'd0;
              if (code == PACK_CODE) begin
                ph_nxt = PH_PACK;
              end else if (code == SYS_CODE && ph_r == PH_CODE_PACK) begin
                ph_nxt = PH_SYS;
              end else if (code >= STREAM_LO && code <= STREAM_HI &&
                           ph_r != PH_CODE_START) begin
                sid_nxt = code[7:0];
                ph_nxt = PH_PLEN;
              end else begin
                do_fail = 1'b1; fail_code = ERR_START_CODE;
              end
            end else begin
              fbc_nxt = fbc_r + 3'd1;
            end
          end
          PH_ENTRY_OR_CODE: begin
            hs0_nxt = {56'd0, in_byte};
            if (in_byte[7]) begin
              sid_nxt = in_byte; fbc_nxt = 3'd0; ph_nxt = PH_ENTRY;
            end else begin
              fbc_nxt = 3'd1; ph_nxt = PH_CODE_MID;
            end
          end
          PH_PACK: begin
            hs0_nxt = sh;
            if ((fbc_r == 3'd0 && in_byte[7:4] != 4'd2) ||
                ((fbc_r == 3'd0 || fbc_r == 3'd2 || fbc_r == 3'd4 || fbc_r == 3'd7) &&
                 !in_byte[0]) ||
                (fbc_r == 3'd5 && !in_byte[7])) begin
              do_fail = 1'b1; fail_code = ERR_MARKER;
            end else if (fbc_r == 3'd7) begin
              fbc_nxt = 3'd0; ph_nxt = PH_CODE_PACK;
              ev_valid = 1'b1;
              ev.kind = KIND_PACK;
              ev.time_stamp = time_of(sh[63:24]);
              ev.rate = sh[22:1];
            end else begin
              fbc_nxt = fbc_r + 3'd1;
            end
          end
          PH_SYS: begin
            hs0_nxt = sh;
            if (fbc_r == 3'd1 && sh[15:0] < 16'd6) begin
              do_fail = 1'b1; fail_code = ERR_SHORT_HDR;
            end else if ((fbc_r == 3'd2 && !in_byte[7]) || (fbc_r == 3'd4 && !in_byte[0]) ||
                         (fbc_r == 3'd6 && !in_byte[5])) begin
              do_fail = 1'b1; fail_code = ERR_MARKER;
            end else if (fbc_r == 3'd7 && in_byte != STUFF_BYTE) begin
              do_fail = 1'b1; fail_code = ERR_RESERVED;
            end else if (fbc_r == 3'd7) begin
              fbc_nxt = 3'd0; ph_nxt = PH_ENTRY_OR_CODE;
              ev_valid = 1'b1;
              ev.kind = KIND_SYSHDR;
              ev.rate = sh[46:25];
              ev.length = sh[63:48];
              ev.system_bounds = {sh[23:18], sh[17:14], sh[12:8]};
            end else begin
              fbc_nxt = fbc_r + 3'd1;
            end
          end
          PH_ENTRY: begin
            hs0_nxt = sh;
            if (fbc_r == 3'd0 && in_byte[7:6] != 2'b11) begin
              do_fail = 1'b1; fail_code = ERR_MARKER;
            end else if (fbc_r == 3'd1) begin
              fbc_nxt = 3'd0; ph_nxt = PH_ENTRY_OR_CODE;
              ev_valid = 1'b1;
              ev.kind = KIND_ENTRY;
              ev.stream_num = sid_r;
              ev.std_scale = sh[13];
              ev.std_size = sh[12:0];
            end else begin
              fbc_nxt = fbc_r + 3'd1;
            end
          end
          PH_PLEN: begin
            hs0_nxt = sh;
            if (fbc_r == 3'd1) begin
              rem_nxt = sh[15:0];
              hs1_nxt = {16'd0, sh[15:0]};
              stuff_nxt = '0; pts_nxt = '0; fbc_nxt = 3'd0; ph_nxt = PH_STUFF;
            end else begin
              fbc_nxt = fbc_r + 3'd1;
            end
          end
          PH_STUFF: begin
            if (in_byte == STUFF_BYTE && stuff_r < STUFF_MAX) begin
              if (rem_r == 16'd0) begin
                do_fail = 1'b1; fail_code = ERR_UNDERFLOW;
              end else begin
                rem_nxt = rem_r - 16'd1;
                stuff_nxt = stuff_r + 1'b1;
              end
            end else if (in_byte[7:6] == 2'b01) begin
              if (rem_r < 16'd2) begin
                do_fail = 1'b1; fail_code = ERR_UNDERFLOW;
              end else begin
                rem_nxt = rem_r - 16'd2;
                hs0_nxt = {56'd0, in_byte};
                ph_nxt = PH_STD;
              end
            end else begin
              do_lead = 1'b1;
            end
          end
          PH_STD: begin
            hs1_nxt = hs1_r | {2'b00, hs0_r[5:0], in_byte, 16'd0};
            ph_nxt = PH_TSLEAD;
          end
          PH_TSLEAD: do_lead = 1'b1;
          PH_PTS: begin
            hs0_nxt = sh;
            if ((fbc_r == 3'd2 || fbc_r == 3'd4) && !in_byte[0]) begin
              do_fail = 1'b1; fail_code = ERR_MARKER;
            end else if (fbc_r == 3'd4) begin
              pts_nxt = time_of(sh[39:0]);
              fbc_nxt = 3'd0;
              if (hs1_r[31:30] == 2'b11) begin
                ph_nxt = PH_DTS;
              end else begin
                do_done = 1'b1; done_pts = time_of(sh[39:0]);
              end
            end else begin
              fbc_nxt = fbc_r + 3'd1;
            end
          end
          PH_DTS: begin
            hs0_nxt = sh;
            if (fbc_r == 3'd0 && in_byte[7:4] != 4'd1) begin
              do_fail = 1'b1; fail_code = ERR_DTS_PREFIX;
            end else if ((fbc_r == 3'd0 || fbc_r == 3'd2 || fbc_r == 3'd4) && !in_byte[0]) begin
              do_fail = 1'b1; fail_code = ERR_MARKER;
            end else if (fbc_r == 3'd0 && rem_r < 16'd5) begin
              do_fail = 1'b1; fail_code = ERR_UNDERFLOW;
            end else begin
              if (fbc_r == 3'd0) begin
                rem_nxt = rem_r - 16'd5;
                done_rem = rem_r - 16'd5;
              end
              if (fbc_r == 3'd4) begin
                do_done = 1'b1; done_dts = time_of(sh[39:0]);
              end else begin
                fbc_nxt = fbc_r + 3'd1;
              end
            end
          end
          PH_DATA: begin
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              fbc_nxt = 3'd0; ph_nxt = PH_CODE_MID;
            end
            ev_valid = 1'b1;
            ev.kind = KIND_DATA;
            ev.stream_num = sid_r;
            ev.data_byte = in_byte;
          end
          default: ;
        endcase

        // byte after stuffing and STD field: timestamp lead or no-timestamp byte
        if (do_lead) begin
          if (in_byte[7:6] != 2'b00) begin
            do_fail = 1'b1; fail_code = ERR_MARKER;
          end else if (f == 2'b01) begin
            do_fail = 1'b1; fail_code = ERR_TS_FLAGS;
          end else if (f == 2'b00) begin
            if (in_byte != NO_TS_BYTE) begin
              do_fail = 1'b1; fail_code = ERR_NO_TS_BYTE;
            end else if (rem_r == 16'd0) begin
              do_fail = 1'b1; fail_code = ERR_UNDERFLOW;
            end else begin
              rem_nxt = rem_r - 16'd1;
              done_rem = rem_r - 16'd1;
              do_done = 1'b1;
            end
          end else if (!in_byte[0]) begin
            do_fail = 1'b1; fail_code = ERR_MARKER;
          end else if (rem_r < 16'd5) begin
            do_fail = 1'b1; fail_code = ERR_UNDERFLOW;
          end else begin
            rem_nxt = rem_r - 16'd5;
            hs1_nxt = hs1_r | {f, 30'd0};
            hs0_nxt = {56'd0, in_byte};
            fbc_nxt = 3'd1;
            ph_nxt = PH_PTS;
          end
        end

        if (do_done) begin
          ev_valid = 1'b1;
          ev.kind = KIND_PACKET;
          ev.stream_num = sid_r;
          ev.time_stamp = hs1_r[31] ? done_pts : 33'd0;
          ev.decode_time = done_dts;
          ev.length = hs1_r[15:0];
          ev.time_flags = hs1_r[31:30];
          ev.std_scale = hs1_r[29];
          ev.std_size = hs1_r[28:16];
          fbc_nxt = 3'd0;
          ph_nxt = (done_rem != 16'd0) ? PH_DATA : PH_CODE_MID;
        end
      end

      if (do_fail) begin
        err_nxt = 1'b1;
        ev_valid = 1'b1;
        ev = '0;
        ev.kind = KIND_ERROR;
        ev.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_CODE_START; fbc_r <= '0; hs0_r <= '0; hs1_r <= '0; rem_r <= '0;
      stuff_r <= '0; sid_r <= '0; pts_r <= '0; err_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; fbc_r <= fbc_nxt; hs0_r <= hs0_nxt; hs1_r <= hs1_nxt;
      rem_r <= rem_nxt; stuff_r <= stuff_nxt; sid_r <= sid_nxt; pts_r <= pts_nxt;
      err_r <= err_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/mss_out_reg.sv */
`default_nettype none
module mss_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic            load_valid,
  input  wire mss_pkg::event_t load_ev,
  input  wire logic            take,
  output logic                 room,
  output logic                 valid,
  output mss_pkg::event_t      ev
);
  import mss_pkg::*;

  logic   valid_r, valid_nxt;
  event_t ev_r;

  // slot is free when empty or being drained this cycle
  assign room = !valid_r || take;
  assign valid_nxt = load ? load_valid : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      ev_r <= load_ev;
    end
  end

  assign valid = valid_r;
  assign ev    = ev_r;

endmodule
`default_nettype wire

/* sv/mpeg1_system_stream_parser.sv */
`default_nettype none
// MPEG-1 system stream parser.
// in_ch carries the stream one byte per beat (in_byte), or an end_of_stream
// beat. out_ch carries at most one event per input beat: pack header, system
// header, stream entry, packet header, payload byte, error or end.
// A beat is taken when valid and ready are both high.
// An event is registered and shows on out_ch in the cycle after its beat.
// Throughput: one byte per cycle; the parse state and the event are worked
// out in one pass between the state registers and the output register.
// in_ch.ready is high while the output register is empty or being drained,
// so a stalled receiver holds the event and stops intake only once the
// register is full; bytes causing no event still need that free slot.
// Reset (rst_n low, synchronous) returns the parser to awaiting a pack start
// code and clears the output register and the sticky error.
// After an error or end event the parser drops every later beat until reset.
module mpeg1_system_stream_parser #(
  parameter int MAX_STUFFING = mss_pkg::MaxStuffingDefault
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mss_in_if.sink     in_ch,
  mss_out_if.source  out_ch
);
  import mss_pkg::*;

  logic   accept;
  logic   room;
  logic   ev_valid;
  event_t ev;
  logic   out_valid;
  event_t out_ev;

  assign in_ch.ready = room;
  assign accept = in_ch.valid && room;

  // parse state and event for this byte
  mss_parse_core #(.MAX_STUFFING(MAX_STUFFING)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (accept),
    .in_byte       (in_ch.in_byte),
    .end_of_stream (in_ch.end_of_stream),
    .ev_valid      (ev_valid),
    .ev            (ev)
  );

  // hold the event until the receiver takes it
  mss_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .load_valid (ev_valid),
    .load_ev    (ev),
    .take       (out_ch.ready),
    .room       (room),
    .valid      (out_valid),
    .ev         (out_ev)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = out_ev.kind;
  assign out_ch.stream_num    = out_ev.stream_num;
  assign out_ch.time_stamp    = out_ev.time_stamp;
  assign out_ch.decode_time   = out_ev.decode_time;
  assign out_ch.rate          = out_ev.rate;
  assign out_ch.length        = out_ev.length;
  assign out_ch.time_flags    = out_ev.time_flags;
  assign out_ch.std_scale     = out_ev.std_scale;
  assign out_ch.std_size      = out_ev.std_size;
  assign out_ch.system_bounds = out_ev.system_bounds;
  assign out_ch.data_byte     = out_ev.data_byte;
  assign out_ch.error_code    = out_ev.error_code;

endmodule
`default_nettype wire

/* verif/mpeg1_system_stream_parser_tb.sv */
`timescale 1ns / 100ps
`default_nettype none

module mpeg1_system_stream_parser_tb;
  import mss_pkg::*;

  typedef enum int {
    P_CODE_START, P_CODE_PACK, P_CODE_MID, P_PACK, P_SYS, P_ENTRY_OR_CODE,
    P_ENTRY, P_PLEN, P_STUFF, P_STD, P_TSLEAD, P_PTS, P_DTS, P_DATA, P_DONE
  } parse_phase_t;

  // Expected events of the demultiplexer, worked out from the accepted bytes.
  class demux_scoreboard;
    event_t       pending_events[$];
    int           fail_count;
    int           event_count;
    int           kind_seen[8];
    parse_phase_t phase;
    int           fcount;
    logic [63:0]  shift0, shift1;
    logic [15:0]  remaining;
    int           stuffed;
    logic [7:0]   cur_stream;
    logic [32:0]  pts_saved;
    bit           latched;

    function new();
      phase = P_CODE_START;
      fcount = 0;
      shift0 = '0;
      shift1 = '0;
      remaining = '0;
      stuffed = 0;
      cur_stream = '0;
      pts_saved = '0;
      latched = 0;
      fail_count = 0;
      event_count = 0;
    endfunction

    function logic [32:0] stamp_of(logic [39:0] v);
      logic [32:0] t;
      t = '0;
      t[32:30] = v[35:33];
      t[29:15] = v[31:17];
      t[14:0]  = v[15:1];
      return t;
    endfunction

    function bit raise(logic [3:0] code, output event_t e);
      latched = 1;
      e = '0;
      e.kind = KIND_ERROR;
      e.error_code = code;
      return 1;
    endfunction

    function bit packet_out(logic [32:0] dts, output event_t e);
      e = '0;
      e.kind = KIND_PACKET;
      e.stream_num = cur_stream;
      e.time_flags = shift1[31:30];
      e.time_stamp = shift1[31] ? pts_saved : '0;
      e.decode_time = dts;
      e.length = shift1[15:0];
      e.std_scale = shift1[29];
      e.std_size = shift1[28:16];
      fcount = 0;
      phase = (remaining != 0) ? P_DATA : P_CODE_MID;
      return 1;
    endfunction

    function bit lead(logic [7:0] b, output event_t e);
      logic [1:0] f;
      f = b[5:4];
      e = '0;
      if (b[7:6] != 2'b00) return raise(ERR_MARKER, e);
      if (f == 2'b01) return raise(ERR_TS_FLAGS, e);
      if (f == 2'b00) begin
        if (b != NO_TS_BYTE) return raise(ERR_NO_TS_BYTE, e);
        if (remaining < 1) return raise(ERR_UNDERFLOW, e);
        remaining--;
        return packet_out('0, e);
      end
      if (!b[0]) return raise(ERR_MARKER, e);
      if (remaining < 5) return raise(ERR_UNDERFLOW, e);
      remaining -= 5;
      shift1[31:30] = shift1[31:30] | f;
      shift0 = {56'd0, b};
      fcount = 1;
      phase = P_PTS;
      return 0;
    endfunction

    function bit judge(output event_t e);
      logic [31:0] code;
      code = shift0[31:0];
      fcount = 0;
      e = '0;
      if (code == PACK_CODE) begin
        phase = P_PACK;
        return 0;
      end
      if (code == SYS_CODE && phase == P_CODE_PACK) begin
        phase = P_SYS;
        return 0;
      end
      if (code >= STREAM_LO && code <= STREAM_HI && phase != P_CODE_START) begin
        cur_stream = code[7:0];
        phase = P_PLEN;
        return 0;
      end
      return raise(ERR_START_CODE, e);
    endfunction

    // Advance the parse by one beat; return 1 with the event if one is due.
    function bit advance(logic [7:0] b, logic eos, output event_t e);
      int i;
      logic [63:0] v;
      i = fcount;
      e = '0;
      if (latched || phase == P_DONE) return 0;
      if (eos) begin
        if (!(phase == P_ENTRY_OR_CODE ||
              (phase inside {P_CODE_START, P_CODE_PACK, P_CODE_MID} && fcount == 0)))
          return raise(ERR_TRUNCATED, e);
        phase = P_DONE;
        e.kind = KIND_END;
        return 1;
      end
      case (phase)
        P_CODE_START, P_CODE_PACK, P_CODE_MID: begin
          shift0 = {shift0[55:0], b};
          fcount++;
          if (fcount < 4) return 0;
          return judge(e);
        end
        P_ENTRY_OR_CODE: begin
          shift0 = {56'd0, b};
          if (b[7]) begin
            cur_stream = b;
            fcount = 0;
            phase = P_ENTRY;
          end else begin
            fcount = 1;
            phase = P_CODE_MID;
          end
          return 0;
        end
        P_PACK: begin
          shift0 = {shift0[55:0], b};
          if (i == 0 && b[7:4] != 4'h2) return raise(ERR_MARKER, e);
          if ((i == 0 || i == 2 || i == 4 || i == 7) && !b[0]) return raise(ERR_MARKER, e);
          if (i == 5 && !b[7]) return raise(ERR_MARKER, e);
          fcount++;
          if (fcount < 8) return 0;
          v = shift0;
          fcount = 0;
          phase = P_CODE_PACK;
          e.kind = KIND_PACK;
          e.time_stamp = stamp_of(v[63:24]);
          e.rate = v[22:1];
          return 1;
        end
        P_SYS: begin
          shift0 = {shift0[55:0], b};
          if (i == 1 && shift0[15:0] < 16'd6) return raise(ERR_SHORT_HDR, e);
          if (i == 2 && !b[7]) return raise(ERR_MARKER, e);
          if (i == 4 && !b[0]) return raise(ERR_MARKER, e);
          if (i == 6 && !b[5]) return raise(ERR_MARKER, e);
          if (i == 7 && b != 8'hFF) return raise(ERR_RESERVED, e);
          fcount++;
          if (fcount < 8) return 0;
          v = shift0;
          fcount = 0;
          phase = P_ENTRY_OR_CODE;
          e.kind = KIND_SYSHDR;
          e.rate = v[46:25];
          e.length = v[63:48];
          e.system_bounds = {v[23:18], v[17:14], v[12:8]};
          return 1;
        end
        P_ENTRY: begin
          shift0 = {shift0[55:0], b};
          if (i == 0 && b[7:6] != 2'b11) return raise(ERR_MARKER, e);
          fcount++;
          if (fcount < 2) return 0;
          fcount = 0;
          phase = P_ENTRY_OR_CODE;
          e.kind = KIND_ENTRY;
          e.stream_num = cur_stream;
          e.std_scale = shift0[13];
          e.std_size = shift0[12:0];
          return 1;
        end
        P_PLEN: begin
          shift0 = {shift0[55:0], b};
          fcount++;
          if (fcount < 2) return 0;
          remaining = shift0[15:0];
          shift1 = {48'd0, remaining};
          stuffed = 0;
          pts_saved = '0;
          fcount = 0;
          phase = P_STUFF;
          return 0;
        end
        P_STUFF: begin
          if (b == STUFF_BYTE && stuffed < MaxStuffingDefault) begin
            if (remaining < 1) return raise(ERR_UNDERFLOW, e);
            remaining--;
            stuffed++;
            return 0;
          end
          if (b[7:6] == 2'b01) begin
            if (remaining < 2) return raise(ERR_UNDERFLOW, e);
            remaining -= 2;
            shift0 = {56'd0, b};
            phase = P_STD;
            return 0;
          end
          return lead(b, e);
        end
        P_STD: begin
          shift1[29:16] = shift1[29:16] | {shift0[5:0], b};
          phase = P_TSLEAD;
          return 0;
        end
        P_TSLEAD: return lead(b, e);
        P_PTS: begin
          shift0 = {shift0[55:0], b};
          if ((i == 2 || i == 4) && !b[0]) return raise(ERR_MARKER, e);
          fcount++;
          if (fcount < 5) return 0;
          pts_saved = stamp_of(shift0[39:0]);
          fcount = 0;
          if (shift1[31:30] == 2'b11) begin
            phase = P_DTS;
            return 0;
          end
          return packet_out('0, e);
        end
        P_DTS: begin
          shift0 = {shift0[55:0], b};
          if (i == 0) begin
            if (b[7:4] != 4'h1) return raise(ERR_DTS_PREFIX, e);
            if (!b[0]) return raise(ERR_MARKER, e);
            if (remaining < 5) return raise(ERR_UNDERFLOW, e);
            remaining -= 5;
          end
          if ((i == 2 || i == 4) && !b[0]) return raise(ERR_MARKER, e);
          fcount++;
          if (fcount < 5) return 0;
          return packet_out(stamp_of(shift0[39:0]), e);
        end
        P_DATA: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            fcount = 0;
            phase = P_CODE_MID;
          end
          e.kind = KIND_DATA;
          e.stream_num = cur_stream;
          e.data_byte = b;
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function void note_beat(logic [7:0] b, logic eos);
      event_t e;
      if (advance(b, eos, e)) pending_events.push_back(e);
    endfunction

    function void field_cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_event(event_t got);
      event_t want;
      if (pending_events.size() == 0) begin
        $error("kind: expected no event, got 0x%0h", got.kind);
        fail_count++;
        return;
      end
      want = pending_events.pop_front();
      event_count++;
      kind_seen[want.kind]++;
      field_cmp("kind", want.kind, got.kind);
      field_cmp("stream_num", want.stream_num, got.stream_num);
      field_cmp("time_stamp", want.time_stamp, got.time_stamp);
      field_cmp("decode_time", want.decode_time, got.decode_time);
      field_cmp("rate", want.rate, got.rate);
      field_cmp("length", want.length, got.length);
      field_cmp("time_flags", want.time_flags, got.time_flags);
      field_cmp("std_scale", want.std_scale, got.std_scale);
      field_cmp("std_size", want.std_size, got.std_size);
      field_cmp("system_bounds", want.system_bounds, got.system_bounds);
      field_cmp("data_byte", want.data_byte, got.data_byte);
      field_cmp("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mss_in_if  in_if();
  mss_out_if out_if();

  mpeg1_system_stream_parser DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  demux_scoreboard sb;
  logic [7:0] stream_bytes[$];
  int  idle_mode;      // 0: receiver idles more, 1: sender idles more, 2: no idling
  bit  hold_request;
  int  beats_sent;

  // Gather the result channel's fields into one event.
  function automatic event_t out_event();
    event_t e;
    e = '0;
    e.kind          = out_if.kind;
    e.stream_num    = out_if.stream_num;
    e.time_stamp    = out_if.time_stamp;
    e.decode_time   = out_if.decode_time;
    e.rate          = out_if.rate;
    e.length        = out_if.length;
    e.time_flags    = out_if.time_flags;
    e.std_scale     = out_if.std_scale;
    e.std_size      = out_if.std_size;
    e.system_bounds = out_if.system_bounds;
    e.data_byte     = out_if.data_byte;
    e.error_code    = out_if.error_code;
    return e;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Sample both channels at the edge; note inputs before checking outputs.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_beat(in_if.in_byte, in_if.end_of_stream);
      if (out_if.valid && out_if.ready) sb.check_event(out_event());
    end
  end

  // Receiver: random back-pressure by phase, plus one long hold-off.
  int  hold_left;
  bit  hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1;
      hold_left = 300;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (idle_mode)
        0: out_if.ready <= ($urandom_range(99) >= 47);
        1: out_if.ready <= ($urandom_range(99) >= 37);
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  // Offer one beat and hold it until it is taken.
  task automatic send_beat(logic [7:0] b, logic eos);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 47 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.end_of_stream <= eos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  function automatic void put_code(logic [7:0] last);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
    stream_bytes.push_back(last);
  endfunction

  // Five bytes of a 33-bit time with its four-bit prefix and markers.
  function automatic void put_stamp(logic [3:0] prefix, logic [32:0] t);
    stream_bytes.push_back({prefix, t[32:30], 1'b1});
    stream_bytes.push_back(t[29:22]);
    stream_bytes.push_back({t[21:15], 1'b1});
    stream_bytes.push_back(t[14:7]);
    stream_bytes.push_back({t[6:0], 1'b1});
  endfunction

  function automatic void put_pack(logic [32:0] scr, logic [21:0] mux);
    put_code(PACK_CODE[7:0]);
    put_stamp(4'h2, scr);
    stream_bytes.push_back({1'b1, mux[21:15]});
    stream_bytes.push_back(mux[14:7]);
    stream_bytes.push_back({mux[6:0], 1'b1});
  endfunction

  function automatic void put_sys_header(logic [15:0] len, logic [21:0] bound,
                                         logic [14:0] bounds, int entries);
    put_code(SYS_CODE[7:0]);
    stream_bytes.push_back(len[15:8]);
    stream_bytes.push_back(len[7:0]);
    stream_bytes.push_back({1'b1, bound[21:15]});
    stream_bytes.push_back(bound[14:7]);
    stream_bytes.push_back({bound[6:0], 1'b1});
    stream_bytes.push_back({bounds[14:9], bounds[8:7]});
    stream_bytes.push_back({bounds[6:5], 1'b1, bounds[4:0]});
    stream_bytes.push_back(8'hFF);
    repeat (entries) begin
      logic [12:0] sz;
      sz = 13'($urandom);
      stream_bytes.push_back(8'($urandom_range(8'hFF, 8'h80)));
      stream_bytes.push_back({2'b11, 1'($urandom), sz[12:8]});
      stream_bytes.push_back(sz[7:0]);
    end
  endfunction

  // ts_kind: 0 no-timestamp byte, 1 PTS, 2 PTS and DTS.
  function automatic void put_packet(logic [7:0] sid, int stuff, bit with_std,
                                     int ts_kind, int payload);
    logic [15:0] len;
    logic [12:0] sz;
    len = 16'(stuff + (with_std ? 2 : 0) + (ts_kind == 0 ? 1 : ts_kind * 5) + payload);
    sz = 13'($urandom);
    put_code(sid);
    stream_bytes.push_back(len[15:8]);
    stream_bytes.push_back(len[7:0]);
    repeat (stuff) stream_bytes.push_back(STUFF_BYTE);
    if (with_std) begin
      stream_bytes.push_back({2'b01, 1'($urandom), sz[12:8]});
      stream_bytes.push_back(sz[7:0]);
    end
    if (ts_kind == 0) stream_bytes.push_back(NO_TS_BYTE);
    if (ts_kind >= 1) put_stamp(ts_kind == 2 ? 4'h3 : 4'h2, {1'($urandom), $urandom});
    if (ts_kind == 2) put_stamp(4'h1, {1'($urandom), $urandom});
    repeat (payload) stream_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [7:0] any_stream();
    return 8'($urandom_range(STREAM_HI[7:0], STREAM_LO[7:0]));
  endfunction

  initial begin
    int last_start;
    int n;
    sb = new();
    idle_mode = 0;
    hold_request = 0;
    beats_sent = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.end_of_stream = 1'b0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme values, every packet shape, full stuffing, empty payload.
    put_pack({33{1'b1}}, {22{1'b1}});
    put_sys_header(16'hFFFF, {22{1'b1}}, {15{1'b1}}, 2);
    put_packet(STREAM_LO[7:0], MaxStuffingDefault, 1, 2, 3);
    put_packet(STREAM_HI[7:0], 0, 0, 0, 0);
    put_pack('0, '0);
    put_sys_header(16'd6, '0, '0, 0);
    put_packet(8'hE0, 1, 1, 1, 1);
    put_packet(8'hC0, 0, 0, 1, 0);

    // Random: well-formed packs and packets with random content.
    while (stream_bytes.size() < 700) begin
      put_pack({1'($urandom), $urandom}, 22'($urandom));
      if ($urandom_range(2) == 0)
        put_sys_header(16'($urandom_range(16'hFFFF, 6)), 22'($urandom),
                       15'($urandom), $urandom_range(3));
      repeat ($urandom_range(4, 1)) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(12);
        put_packet(any_stream(),
                   ($urandom_range(3) == 0) ? $urandom_range(MaxStuffingDefault) : 0,
                   1'($urandom), $urandom_range(2), n);
      end
    end

    // Close with a last packet, possibly over-stuffed, and flip one of its bits half the time.
    last_start = stream_bytes.size();
    put_packet(any_stream(), $urandom_range(MaxStuffingDefault + 1), 1'($urandom),
               $urandom_range(2), $urandom_range(4));
    if ($urandom_range(1)) begin
      n = $urandom_range(stream_bytes.size() - 1, last_start);
      stream_bytes[n] = stream_bytes[n] ^ (8'h01 << $urandom_range(7));
    end

    foreach (stream_bytes[k]) begin
      if (k == stream_bytes.size() / 3) idle_mode = 1;
      if (k == 2 * stream_bytes.size() / 3) idle_mode = 2;
      if (k == stream_bytes.size() / 2) hold_request = 1;
      send_beat(stream_bytes[k], 1'b0);
    end
    send_beat(8'($urandom), 1'b1);
    // Beats after the end are dropped by the block.
    send_beat(8'($urandom), 1'b0);
    in_if.valid <= 1'b0;

    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Parsed %0d beats into %0d events: %0d packs, %0d system headers,",
             beats_sent, sb.event_count, sb.kind_seen[KIND_PACK], sb.kind_seen[KIND_SYSHDR]);
    $display("%0d entries, %0d packets, %0d payload bytes, %0d errors, %0d ends.",
             sb.kind_seen[KIND_ENTRY], sb.kind_seen[KIND_PACKET], sb.kind_seen[KIND_DATA],
             sb.kind_seen[KIND_ERROR], sb.kind_seen[KIND_END]);
    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* mpeg1_system_stream_parser.f */
sv/mss_pkg.sv
sv/mss_ifs.sv
sv/mss_parse_core.sv
sv/mss_out_reg.sv
sv/mpeg1_system_stream_parser.sv
verif/mpeg1_system_stream_parser_tb.sv
